@@ design/sps_pkg.sv @@
// Shared types and codes for the sprite pixel sequencer.
// No dependencies; every other file of the block imports this package.
package sps_pkg;

	localparam logic [1:0] MODE_PIXEL = 2'd0;
	localparam logic [1:0] MODE_LOAD  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [2:0] REG_MULTICOLOR = 3'd0;
	localparam logic [2:0] REG_EXPAND_X   = 3'd1;
	localparam logic [2:0] REG_POS_LOW    = 3'd2;
	localparam logic [2:0] REG_POS_HIGH   = 3'd3;
	localparam logic [2:0] REG_COLORS     = 3'd4;
	localparam logic [2:0] REG_SHARED     = 3'd5;
	localparam logic [2:0] REG_CONTROL    = 3'd6;

	localparam int          CFG_DATA_W    = 36;
	localparam logic [2:0]  CONTROL_RESET = 3'd6;

	typedef struct packed {
		logic [1:0]  mode;
		logic [8:0]  x_position;
		logic [7:0]  enable_mask;
		logic [7:0]  freeze_mask;
		logic        foreground;
		logic [2:0]  load_sprite;
		logic [23:0] load_data;
	} sps_in_t;

	typedef struct packed {
		logic       pixel_drawn;
		logic [2:0] sprite_number;
		logic [3:0] pixel_color;
		logic [7:0] overlap_mask;
		logic [7:0] sprite_collisions;
		logic [7:0] background_collisions;
		logic       sprite_irq;
		logic       background_irq;
		logic [7:0] active_mask;
	} sps_out_t;

	typedef struct packed {
		logic [2:0]            index;
		logic [CFG_DATA_W-1:0] data;
	} sps_cfg_t;

	// Per-shifter controls for one step
	typedef struct packed {
		logic        pixel;      // pixel step fires this cycle
		logic        load;       // load step addressed to this shifter
		logic        enable;
		logic        freeze;
		logic        multicolor;
		logic        expand_x;
		logic        x_match;
		logic [23:0] load_data;
	} sps_ctl_t;

	// Per-shifter status after the step
	typedef struct packed {
		logic       draw;        // running with nonzero color bits
		logic [1:0] color_bits;
		logic       active;
	} sps_stat_t;

endpackage

@@ design/sps_pix_in_if.sv @@
// Pixel/command input channel of the sprite pixel sequencer.
// Depends on sps_pkg for the payload type.
interface sps_pix_in_if;
	import sps_pkg::*;
	logic    valid;
	logic    ready;
	sps_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/sps_pix_out_if.sv @@
// Result channel of the sprite pixel sequencer.
// Depends on sps_pkg for the payload type.
interface sps_pix_out_if;
	import sps_pkg::*;
	logic     valid;
	logic     ready;
	sps_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/sps_cfg_if.sv @@
// Register write channel of the sprite pixel sequencer.
// Depends on sps_pkg for the payload type.
interface sps_cfg_if;
	import sps_pkg::*;
	logic     valid;
	logic     ready;
	sps_cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ design/sps_shifter.sv @@
// One sprite shifter: 24-bit data, color bits, stretch and multicolor flops.
// Depends on sps_pkg.
module sps_shifter (
	input  logic             clk,
	input  logic             arst_n,
	input  sps_pkg::sps_ctl_t  ctl,
	output sps_pkg::sps_stat_t stat
);
	import sps_pkg::*;

	logic [23:0] shift_q, shift_n;
	logic [1:0]  cbits_q, cbits_n;
	logic        stretch_q, stretch_n;
	logic        mcf_q, mcf_n;
	logic        active_q, active_n;

	logic start, act_eff, stretch_eff, mcf_eff, run, shifting;

	always_comb begin
		start       = ctl.pixel && ctl.enable && !active_q && ctl.x_match && !ctl.freeze;
		act_eff     = active_q || start;
		stretch_eff = start ? 1'b1 : stretch_q;
		mcf_eff     = start ? 1'b1 : mcf_q;
		run         = ctl.pixel && act_eff && !ctl.freeze;
		shifting    = run && stretch_eff;

		shift_n   = shift_q;
		cbits_n   = cbits_q;
		mcf_n     = mcf_eff;
		stretch_n = run ? (!stretch_eff || !ctl.expand_x) : stretch_eff;
		active_n  = act_eff;

		if (ctl.load) begin
			shift_n = ctl.load_data;
		end else if (shifting) begin
			shift_n = {shift_q[22:0], 1'b0};
			if (ctl.multicolor) begin
				if (mcf_eff) begin
					cbits_n = shift_q[23:22];
				end
				mcf_n = !mcf_eff;
			end else begin
				cbits_n = {shift_q[23], 1'b0};
			end
			if (shift_n == 24'd0 && cbits_n == 2'd0) begin
				active_n = 1'b0;
			end
		end

		stat.draw       = ctl.pixel && act_eff && (cbits_n != 2'd0);
		stat.color_bits = cbits_n;
		stat.active     = active_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q   <= '0;
			cbits_q   <= '0;
			stretch_q <= 1'b0;
			mcf_q     <= 1'b0;
			active_q  <= 1'b0;
		end else if (ctl.pixel || ctl.load) begin
			shift_q   <= shift_n;
			cbits_q   <= cbits_n;
			stretch_q <= stretch_n;
			mcf_q     <= mcf_n;
			active_q  <= active_n;
		end
	end

endmodule

@@ design/sprite_pixel_sequencer.sv @@
// Sprite pixel sequencer: top level. Uses sps_pkg, the three channel
// interfaces and sps_shifter (one per sprite).
//
// Takes one item per cycle (pixel step, shift-register load or collision
// clear) while the result side keeps up, and returns exactly one result
// per item. An accepted item sits in an input register; in the cycle it
// can move on, all sprite shifters advance in parallel, priority and
// collision logic run, and the result lands in the output register at the
// next edge. The input side keeps accepting while a result waits, until
// the input register is also full. Each result reports the winning
// (lowest-numbered) sprite and its color, the overlap of all drawing
// sprites, the collision latches and the running-shifter mask after the
// step, plus IRQ flags on the first sprite-sprite and first
// sprite-background collision since the latches were last cleared.
// Register writes take effect at once (cfg ready is always high) and should
// only be issued while no item is in flight. SPRITE_COUNT (1..8) sets how
// many shifters exist; mask bits above it read as zero.
module sprite_pixel_sequencer #(
	parameter int SPRITE_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	sps_cfg_if.sink     cfg,
	sps_pix_in_if.sink  pix_in,
	sps_pix_out_if.source pix_out
);
	import sps_pkg::*;

	// Configuration registers
	logic [7:0]  multicolor_q;
	logic [7:0]  expand_x_q;
	logic [35:0] pos_low_q;
	logic [35:0] pos_high_q;
	logic [31:0] colors_q;
	logic [7:0]  shared_q;
	logic [2:0]  control_q;

	// Input stage and output register
	logic     valid_s1;
	sps_in_t  item_s1;
	logic     out_valid_q;
	sps_out_t out_q;
	logic     advance;

	// Collision latches
	logic [7:0] sprite_hits_q, bg_hits_q;

	sps_ctl_t  ctl  [SPRITE_COUNT];
	sps_stat_t stat [SPRITE_COUNT];

	logic       is_pixel;
	logic [7:0] draw_vec, active_vec, overlap;
	logic [2:0] winner;
	logic [1:0] win_bits;
	logic [3:0] win_color;
	logic       multi_hit, sprite_hit_now, bg_hit_now;
	logic [7:0] sprite_hits_n, bg_hits_n;
	sps_out_t   result;

	function automatic logic [3:0] pick_color(input logic [1:0] bits,
		input logic [3:0] own, input logic [7:0] shared);
		logic [3:0] c;
		case (bits)
			2'd1:    c = shared[3:0];
			2'd2:    c = own;
			default: c = shared[7:4];
		endcase
		return c;
	endfunction

	// ---------------- configuration port ----------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			multicolor_q <= '0;
			expand_x_q   <= '0;
			pos_low_q    <= '0;
			pos_high_q   <= '0;
			colors_q     <= '0;
			shared_q     <= '0;
			control_q    <= CONTROL_RESET;
		end else if (cfg.valid) begin
			case (cfg.data.index)
				REG_MULTICOLOR: multicolor_q <= cfg.data.data[7:0];
				REG_EXPAND_X:   expand_x_q   <= cfg.data.data[7:0];
				REG_POS_LOW:    pos_low_q    <= cfg.data.data;
				REG_POS_HIGH:   pos_high_q   <= cfg.data.data;
				REG_COLORS:     colors_q     <= cfg.data.data[31:0];
				REG_SHARED:     shared_q     <= cfg.data.data[7:0];
				REG_CONTROL:    control_q    <= cfg.data.data[2:0];
				default: ;  // unused index: write dropped
			endcase
		end
	end

	// ---------------- handshake ----------------
	// The item in the input register is worked on in the cycle it can move
	// into the output register.
	assign advance      = valid_s1 && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !valid_s1 || advance;
	assign is_pixel     = advance && (item_s1.mode == MODE_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pix_in.ready) begin
			valid_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_in.ready && pix_in.valid) begin
			item_s1 <= pix_in.data;
		end
	end

	// ---------------- sprite shifters ----------------
	for (genvar s = 0; s < SPRITE_COUNT; s++) begin : g_spr
		logic [35:0] grp;
		assign grp = (s < 4) ? pos_low_q : pos_high_q;

		always_comb begin
			ctl[s].pixel      = is_pixel;
			ctl[s].load       = advance && (item_s1.mode == MODE_LOAD)
			                    && (item_s1.load_sprite == 3'(s));
			ctl[s].enable     = item_s1.enable_mask[s];
			ctl[s].freeze     = item_s1.freeze_mask[s];
			ctl[s].multicolor = multicolor_q[s];
			ctl[s].expand_x   = expand_x_q[s];
			ctl[s].x_match    = (item_s1.x_position == grp[9*(s%4) +: 9]);
			ctl[s].load_data  = item_s1.load_data;
		end

		sps_shifter u_shifter (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl[s]),
			.stat   (stat[s])
		);
	end

	// ---------------- priority and collisions ----------------
	always_comb begin
		draw_vec   = '0;
		active_vec = '0;
		for (int s = 0; s < SPRITE_COUNT; s++) begin
			draw_vec[s]   = stat[s].draw;
			active_vec[s] = stat[s].active;
		end

		// hide flag blanks all sprite pixels, which also masks collisions
		overlap = control_q[0] ? 8'd0 : draw_vec;

		// lowest-numbered drawing sprite wins
		winner   = '0;
		win_bits = '0;
		for (int s = SPRITE_COUNT - 1; s >= 0; s--) begin
			if (overlap[s]) begin
				winner   = 3'(s);
				win_bits = stat[s].color_bits;
			end
		end
		win_color = pick_color(win_bits, colors_q[4*winner +: 4], shared_q);

		multi_hit      = (overlap & (overlap - 8'd1)) != 8'd0;
		sprite_hit_now = is_pixel && multi_hit && control_q[1];
		bg_hit_now     = is_pixel && (overlap != 8'd0) && item_s1.foreground
		                 && control_q[2];

		sprite_hits_n = sprite_hits_q;
		bg_hits_n     = bg_hits_q;
		if (advance && item_s1.mode == MODE_CLEAR) begin
			sprite_hits_n = '0;
			bg_hits_n     = '0;
		end else begin
			if (sprite_hit_now) sprite_hits_n = sprite_hits_q | overlap;
			if (bg_hit_now)     bg_hits_n     = bg_hits_q | overlap;
		end

		result.pixel_drawn           = overlap != 8'd0;
		result.sprite_number         = winner;
		result.pixel_color           = (overlap != 8'd0) ? win_color : 4'd0;
		result.overlap_mask          = overlap;
		result.sprite_collisions     = sprite_hits_n;
		result.background_collisions = bg_hits_n;
		result.sprite_irq            = sprite_hit_now && (sprite_hits_q == 8'd0);
		result.background_irq        = bg_hit_now && (bg_hits_q == 8'd0);
		result.active_mask           = active_vec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sprite_hits_q <= '0;
			bg_hits_q     <= '0;
		end else if (advance) begin
			sprite_hits_q <= sprite_hits_n;
			bg_hits_q     <= bg_hits_n;
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || pix_out.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign pix_out.valid = out_valid_q;
	assign pix_out.data  = out_q;

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sprite pixel sequencer (sprite_pixel_sequencer).
// Depends on sps_pkg and the sps_cfg_if, sps_pix_in_if and sps_pix_out_if channels.
// An in-file sprite model predicts every result. Directed and random items run with idling, except while steady is set.
module testbench;
	import sps_pkg::*;

	// mode code with no operation behind it (both mode bits set)
	localparam logic [1:0] MODE_NOP    = 2'd3;
	// register index past the end of the register file, must be ignored
	localparam logic [2:0] REG_UNUSED  = 3'd7;
	localparam int         IDLE_PCT    = 36;
	localparam int         STALL_LIMIT = 2000;
	localparam int         TAIL_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n;

	sps_cfg_if     cfg();
	sps_pix_in_if  pix_in();
	sps_pix_out_if pix_out();

	sprite_pixel_sequencer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.pix_in (pix_in),
		.pix_out(pix_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Sprite model: register copies and per-sprite shifter state
	// ---------------------------------------------------------------
	logic [7:0]  cfg_multicolor = '0;
	logic [7:0]  cfg_expand     = '0;
	logic [35:0] cfg_pos_low    = '0;
	logic [35:0] cfg_pos_high   = '0;
	logic [31:0] cfg_colors     = '0;
	logic [7:0]  cfg_shared     = '0;
	logic [2:0]  cfg_control    = CONTROL_RESET;

	logic [23:0] shift_reg [8] = '{default: '0};
	logic [1:0]  pix_bits  [8] = '{default: '0};
	logic        stretch_q [8] = '{default: 1'b0};
	logic        mc_phase  [8] = '{default: 1'b0};
	logic [7:0]  running       = '0;
	logic [7:0]  sprite_latch  = '0;
	logic [7:0]  bg_latch      = '0;

	// register values that program_registers writes, by register index
	logic [35:0] reg_image [0:6];

	sps_out_t expected_results [$];
	int       error_count = 0;
	bit       steady = 1'b0;	// no idling on either side while set
	int       stall_cycles = 0;

	// Advance the sprite model by one item and return the result it produces.
	function automatic sps_out_t next_pixel_result(input sps_in_t it);
		sps_out_t    r;
		logic [35:0] grp;
		logic [8:0]  start_pos;
		logic [7:0]  hit;
		logic        en;
		logic        frz;
		int          s;
		r = '0;
		hit = '0;
		case (it.mode)
			MODE_LOAD: begin
				shift_reg[it.load_sprite] = it.load_data;
			end
			MODE_CLEAR: begin
				sprite_latch = '0;
				bg_latch = '0;
			end
			MODE_PIXEL: begin
				for (s = 0; s < 8; s++) begin
					en = it.enable_mask[s];
					frz = it.freeze_mask[s];
					grp = (s < 4) ? cfg_pos_low : cfg_pos_high;
					start_pos = grp[9*(s%4) +: 9];
					// idle, enabled, unfrozen shifter at its X starts with both flops set
					if (en && !running[s] && it.x_position == start_pos && !frz) begin
						running[s] = 1'b1;
						stretch_q[s] = 1'b1;
						mc_phase[s] = 1'b1;
					end
					if (running[s]) begin
						if (!frz) begin
							if (stretch_q[s]) begin
								if (cfg_multicolor[s]) begin
									// two-bit pixel picked up every other shift
									if (mc_phase[s])
										pix_bits[s] = shift_reg[s][23:22];
									mc_phase[s] = !mc_phase[s];
								end else begin
									pix_bits[s] = {shift_reg[s][23], 1'b0};
								end
								shift_reg[s] = shift_reg[s] << 1;
								if (shift_reg[s] == '0 && pix_bits[s] == '0)
									running[s] = 1'b0;
							end
							stretch_q[s] = !stretch_q[s] || !cfg_expand[s];
						end
						// hidden sprites still shift but never draw
						if (pix_bits[s] != '0 && !cfg_control[0]) begin
							if (hit == '0) begin
								r.pixel_drawn = 1'b1;
								r.sprite_number = 3'(s);
								case (pix_bits[s])
									2'd1:    r.pixel_color = cfg_shared[3:0];
									2'd2:    r.pixel_color = cfg_colors[4*s +: 4];
									default: r.pixel_color = cfg_shared[7:4];
								endcase
							end
							hit[s] = 1'b1;
						end
					end
				end
				r.overlap_mask = hit;
				if (hit != '0) begin
					// irq only on the first hit since the latch was last empty
					if ((hit & (hit - 8'd1)) != '0 && cfg_control[1]) begin
						if (sprite_latch == '0)
							r.sprite_irq = 1'b1;
						sprite_latch |= hit;
					end
					if (it.foreground && cfg_control[2]) begin
						if (bg_latch == '0)
							r.background_irq = 1'b1;
						bg_latch |= hit;
					end
				end
			end
			default: ;	// no-op mode leaves all state alone
		endcase
		r.sprite_collisions = sprite_latch;
		r.background_collisions = bg_latch;
		r.active_mask = running;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Item builders; fields the mode ignores carry random values
	// ---------------------------------------------------------------
	function automatic sps_in_t random_item();
		sps_in_t r;
		r.mode = 2'($urandom_range(3));
		r.x_position = 9'($urandom);
		r.enable_mask = 8'($urandom);
		r.freeze_mask = 8'($urandom);
		r.foreground = 1'($urandom);
		r.load_sprite = 3'($urandom);
		r.load_data = 24'($urandom);
		return r;
	endfunction

	function automatic sps_in_t pixel_item(input logic [8:0] x, input logic [7:0] en,
			input logic [7:0] frz, input logic fg);
		sps_in_t r;
		r = random_item();
		r.mode = MODE_PIXEL;
		r.x_position = x;
		r.enable_mask = en;
		r.freeze_mask = frz;
		r.foreground = fg;
		return r;
	endfunction

	function automatic sps_in_t load_item(input logic [2:0] sprite, input logic [23:0] bits);
		sps_in_t r;
		r = random_item();
		r.mode = MODE_LOAD;
		r.load_sprite = sprite;
		r.load_data = bits;
		return r;
	endfunction

	function automatic sps_in_t command_item(input logic [1:0] mode);
		sps_in_t r;
		r = random_item();
		r.mode = mode;
		return r;
	endfunction

	// sprite bitmap rows: dense, sparse, solid or a single bar
	function automatic logic [23:0] shaped_data();
		case ($urandom_range(3))
			0:       return 24'($urandom);
			1:       return 24'($urandom & $urandom & $urandom);
			2:       return 24'hFFFFFF;
			default: return 24'hFF << (8 * $urandom_range(2));
		endcase
	endfunction

	// ---------------------------------------------------------------
	// Channel drivers
	// ---------------------------------------------------------------
	// One input transfer; valid stays high afterwards so back-to-back items
	// need no extra edge. Prediction is taken at the transfer edge.
	task automatic send_item(input sps_in_t it);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			pix_in.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		pix_in.valid <= 1'b1;
		pix_in.data <= it;
		do @(posedge clk); while (!pix_in.ready);
		expected_results.push_back(next_pixel_result(it));
	endtask

	// Stop sending and hold until every predicted result has come back.
	task automatic settle_results();
		pix_in.valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Single register write; caller lowers cfg.valid after the last one.
	task automatic write_reg(input logic [2:0] index, input logic [35:0] value);
		cfg.valid <= 1'b1;
		cfg.data <= '{index: index, data: value};
		do @(posedge clk); while (!cfg.ready);
		case (index)
			REG_MULTICOLOR: cfg_multicolor = value[7:0];
			REG_EXPAND_X:   cfg_expand     = value[7:0];
			REG_POS_LOW:    cfg_pos_low    = value;
			REG_POS_HIGH:   cfg_pos_high   = value;
			REG_COLORS:     cfg_colors     = value[31:0];
			REG_SHARED:     cfg_shared     = value[7:0];
			REG_CONTROL:    cfg_control    = value[2:0];
			default: ;
		endcase
	endtask

	// Drain, then write the whole register image (plus the unused index if asked).
	task automatic program_registers(input bit with_unused);
		int i;
		settle_results();
		for (i = 0; i <= 6; i++)
			write_reg(3'(i), reg_image[i]);
		if (with_unused)
			write_reg(REG_UNUSED, '1);
		cfg.valid <= 1'b0;
	endtask

	// One raster sweep: refill some shifters, then walk X across the start window.
	task automatic scan_line(input logic [8:0] base);
		logic [7:0] en;
		logic [7:0] frz;
		logic [8:0] x;
		int         i;
		int         s;
		for (s = 0; s < 8; s++)
			if ($urandom_range(3) != 0)
				send_item(load_item(3'(s), shaped_data()));
		en = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
		x = base - 9'($urandom_range(4));
		for (i = 0; i < 70; i++) begin
			// enables drop mid-line now and then: running shifters must carry on
			if ($urandom_range(99) < 5)
				en = 8'($urandom);
			frz = ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00;
			case ($urandom_range(49))
				0:       send_item(command_item(MODE_CLEAR));
				1:       send_item(random_item());
				default: send_item(pixel_item(x, en, frz, 1'($urandom)));
			endcase
			x = x + 9'd1;
		end
	endtask

	// Program a setting with start positions clustered near a random X, then sweep.
	task automatic run_phase(input logic [7:0] mc, input logic [7:0] xe,
			input logic [2:0] ctrl, input int lines);
		logic [8:0] base;
		logic [8:0] pos [8];
		int         s;
		int         l;
		base = 9'($urandom);
		for (s = 0; s < 8; s++)
			pos[s] = base + 9'($urandom_range(40));
		reg_image[REG_MULTICOLOR] = 36'(mc);
		reg_image[REG_EXPAND_X] = 36'(xe);
		reg_image[REG_POS_LOW] = {pos[3], pos[2], pos[1], pos[0]};
		reg_image[REG_POS_HIGH] = {pos[7], pos[6], pos[5], pos[4]};
		reg_image[REG_COLORS] = 36'($urandom);
		reg_image[REG_SHARED] = 36'($urandom_range(255));
		reg_image[REG_CONTROL] = 36'(ctrl);
		program_registers(1'b0);
		for (l = 0; l < lines; l++)
			scan_line(base);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Hand-picked sequence: starts at both X extremes, frozen start, empty
	// sprite, collisions and their irqs, clear, disabled-but-running, hiding.
	task automatic test_directed();
		reg_image[REG_MULTICOLOR] = 36'h02;
		reg_image[REG_EXPAND_X] = 36'h01;
		reg_image[REG_POS_LOW] = {9'd511, 9'd0, 9'd11, 9'd10};
		reg_image[REG_POS_HIGH] = {9'd12, 9'd511, 9'd511, 9'd511};
		reg_image[REG_COLORS] = 36'hFEDCBA980;
		reg_image[REG_SHARED] = 36'h5A;
		reg_image[REG_CONTROL] = 36'(CONTROL_RESET);
		program_registers(1'b1);
		send_item(load_item(3'd0, 24'hFFFFFF));
		send_item(load_item(3'd1, 24'hC00001));
		send_item(load_item(3'd7, 24'h800000));
		send_item(load_item(3'd3, 24'hFFFFFF));
		send_item(load_item(3'd2, 24'h000000));
		send_item(command_item(MODE_NOP));
		send_item(pixel_item(9'd9, 8'h83, 8'h00, 1'b1));	// no X match yet
		send_item(pixel_item(9'd10, 8'h83, 8'h02, 1'b1));	// sprite 0 starts
		send_item(pixel_item(9'd11, 8'h83, 8'h00, 1'b1));	// sprite 1 starts, overlap
		send_item(pixel_item(9'd12, 8'h83, 8'h00, 1'b1));	// sprite 7 starts
		send_item(pixel_item(9'd13, 8'h01, 8'h80, 1'b0));	// disabled but running
		send_item(command_item(MODE_CLEAR));
		send_item(pixel_item(9'd14, 8'h00, 8'h00, 1'b1));	// background irq fires again
		send_item(pixel_item(9'd0, 8'h04, 8'h00, 1'b1));	// empty sprite stops at once
		send_item(pixel_item(9'd511, 8'h08, 8'h00, 1'b1));
		send_item(pixel_item(9'd0, 8'hFF, 8'hFF, 1'b1));	// everything frozen
		reg_image[REG_CONTROL] = 36'd1;	// hide sprites
		program_registers(1'b0);
		send_item(pixel_item(9'd1, 8'h00, 8'h00, 1'b1));
		send_item(pixel_item(9'd2, 8'hFF, 8'h00, 1'b1));
		reg_image[REG_CONTROL] = 36'd0;	// visible, no collision checks
		program_registers(1'b0);
		send_item(pixel_item(9'd3, 8'hFF, 8'h00, 1'b1));
		send_item(pixel_item(9'd4, 8'hFF, 8'h00, 1'b1));
	endtask

	// Reset-like setting with no idling on either side.
	task automatic test_plain_sprites();
		steady = 1'b1;
		run_phase(8'h00, 8'h00, CONTROL_RESET, 3);
		steady = 1'b0;
	endtask

	task automatic test_wide_multicolor();
		run_phase(8'hFF, 8'hFF, 3'd7, 2);
		run_phase(8'hFF, 8'hFF, CONTROL_RESET, 3);
	endtask

	task automatic test_collision_controls();
		run_phase(8'($urandom), 8'($urandom), 3'd0, 3);
		run_phase(8'($urandom), 8'($urandom), 3'd2, 2);
		run_phase(8'($urandom), 8'($urandom), 3'd4, 2);
	endtask

	task automatic test_random_settings();
		int k;
		for (k = 0; k < 3; k++)
			run_phase(8'($urandom), 8'($urandom), 3'($urandom_range(7)), 2);
	endtask

	// Unstructured items; the sender fully drains once halfway through.
	task automatic test_noise();
		int k;
		for (k = 0; k < 150; k++) begin
			if (k == 75)
				settle_results();
			send_item(random_item());
		end
	endtask

	// ---------------------------------------------------------------
	// Result checking and receiver stalls
	// ---------------------------------------------------------------
	task automatic compare_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : result_check
		sps_out_t want;
		if (arst_n) begin
			if (pix_out.valid && pix_out.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result with no pending item: expected none, got %h",
						$time, pix_out.data);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					compare_field("pixel_drawn", 8'(want.pixel_drawn),
						8'(pix_out.data.pixel_drawn));
					compare_field("sprite_number", 8'(want.sprite_number),
						8'(pix_out.data.sprite_number));
					compare_field("pixel_color", 8'(want.pixel_color),
						8'(pix_out.data.pixel_color));
					compare_field("overlap_mask", want.overlap_mask, pix_out.data.overlap_mask);
					compare_field("sprite_collisions", want.sprite_collisions,
						pix_out.data.sprite_collisions);
					compare_field("background_collisions", want.background_collisions,
						pix_out.data.background_collisions);
					compare_field("sprite_irq", 8'(want.sprite_irq),
						8'(pix_out.data.sprite_irq));
					compare_field("background_irq", 8'(want.background_irq),
						8'(pix_out.data.background_irq));
					compare_field("active_mask", want.active_mask, pix_out.data.active_mask);
				end
			end
			pix_out.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end else begin
			pix_out.ready <= 1'b0;
		end
	end

	// Watchdog: any transfer on any channel counts as progress.
	always @(posedge clk) begin
		if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready) ||
				(cfg.valid && cfg.ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Test sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n <= 1'b0;
		pix_in.valid <= 1'b0;
		pix_in.data <= '0;
		cfg.valid <= 1'b0;
		cfg.data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_plain_sprites();
		test_wide_multicolor();
		test_collision_controls();
		test_random_settings();
		test_noise();

		// let the pipeline empty, then a short tail for stray results
		settle_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
